[design/tgt_pkg.sv]
// Shared types and constants for the touchpad gesture tracker.
// No dependencies.
`timescale 1ns / 1ps

package tgt_pkg;

  // Event codes on the input channel
  localparam logic [2:0] OP_X    = 3'd0;
  localparam logic [2:0] OP_Y    = 3'd1;
  localparam logic [2:0] OP_REL  = 3'd2;
  localparam logic [2:0] OP_TICK = 3'd4;

  // Result kinds
  localparam logic [1:0] KIND_LEFT   = 2'd0;
  localparam logic [1:0] KIND_RIGHT  = 2'd1;
  localparam logic [1:0] KIND_MOTION = 2'd2;

  // Configuration register indexes
  localparam logic [2:0] CFG_X_GAIN     = 3'd0;
  localparam logic [2:0] CFG_Y_GAIN     = 3'd1;
  localparam logic [2:0] CFG_JUMP_THR   = 3'd2;
  localparam logic [2:0] CFG_DRIFT_THR  = 3'd3;
  localparam logic [2:0] CFG_HOLD_TICKS = 3'd4;

  // Configuration reset values
  localparam logic [23:0] RST_X_GAIN     = 24'd110928;
  localparam logic [23:0] RST_Y_GAIN     = 24'd87727;
  localparam logic [8:0]  RST_JUMP_THR   = 9'd10;
  localparam logic [15:0] RST_DRIFT_THR  = 16'd10;
  localparam logic [15:0] RST_HOLD_TICKS = 16'd1;

  typedef struct packed {
    logic [1:0]        kind;
    logic signed [8:0] dx;
    logic signed [8:0] dy;
    logic              last;
  } result_t;

  // Up to two results per event; push1 only alongside push0
  typedef struct packed {
    logic    push0;
    logic    push1;
    result_t r0;
    result_t r1;
  } push_t;

endpackage

[design/tgt_scale.sv]
// Sample scaler: ((value + 32767) * gain) >> 24, saturated to 0..255.
// Depends on nothing but its ports.
`timescale 1ns / 1ps

module tgt_scale (
  input  logic signed [15:0] value,
  input  logic [23:0]        gain,
  output logic [7:0]         pix
);

  logic        neg;
  logic [15:0] offs;
  logic [39:0] prod;
  logic [15:0] whole;

  // -32768 is the only sample whose offset value goes negative
  assign neg   = (value == -16'sd32768);
  assign offs  = 16'(value + 16'sd32767);
  assign prod  = {24'd0, offs} * {16'd0, gain};
  assign whole = prod[39:24];

  always_comb begin
    if (neg) begin
      pix = 8'd0;
    end else if (|whole[15:8]) begin
      pix = 8'd255;
    end else begin
      pix = whole[7:0];
    end
  end

endmodule

[design/tgt_result_queue.sv]
// Small result queue between the event processor and the output channel.
// Takes up to two results per cycle, gives one per cycle while pop_ready is high. Uses tgt_pkg.
`timescale 1ns / 1ps

module tgt_result_queue #(
  parameter int DEPTH = 4
) (
  input  logic            clk,
  input  logic            rst_n,
  input  tgt_pkg::push_t  push,
  input  logic            pop_ready,
  output logic            head_valid,
  output tgt_pkg::result_t head,
  output logic            room2
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
  localparam logic [CW-1:0] ROOM_MAX = CW'(DEPTH - 2);

  tgt_pkg::result_t mem_r [DEPTH];
  logic [PW-1:0] wptr_r, wptr_nxt, wptr_p1;
  logic [PW-1:0] rptr_r, rptr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          pop;

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    ptr_inc = (p == LAST_PTR) ? '0 : p + PW'(1);
  endfunction

  assign head_valid = (cnt_r != '0);
  assign head       = mem_r[rptr_r];
  assign room2      = (cnt_r <= ROOM_MAX);
  assign pop        = head_valid && pop_ready;
  assign wptr_p1    = ptr_inc(wptr_r);

  always_comb begin
    wptr_nxt = wptr_r;
    if (push.push1) begin
      wptr_nxt = ptr_inc(wptr_p1);
    end else if (push.push0) begin
      wptr_nxt = wptr_p1;
    end
    rptr_nxt = pop ? ptr_inc(rptr_r) : rptr_r;
    cnt_nxt  = cnt_r + CW'(push.push0) + CW'(push.push1) - CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push.push0) begin
      mem_r[wptr_r] <= push.r0;
    end
    if (push.push1) begin
      mem_r[wptr_p1] <= push.r1;
    end
  end

endmodule

[design/touchpad_gesture_tracker.sv]
// Touchpad gesture tracker, top level.
// Uses tgt_pkg, tgt_scale and tgt_result_queue.
`timescale 1ns / 1ps

// Usage
// - Input channel (in_valid/in_ready, in_op, in_value): one touchpad event per
//   transaction: X sample, Y sample, release, other event, or time tick.
// - Output channel (out_valid/out_ready, out_kind, out_dx, out_dy, out_last):
//   one click or motion result per transaction; out_last marks the final
//   result of an event. A release may give a click followed by a motion.
// - Config channel (cfg_valid/cfg_ready, cfg_index, cfg_data): cfg_ready is
//   always high; indexes beyond hold_ticks are dropped. Write only while idle.
// - Path: an event taken on the input channel is scaled through the one
//   multiplier and registered in stage A, evaluated against the tracker state
//   in stage B and written into the result queue, whose head is offered.
// - Throughput: one event per cycle while two queue slots are free. The output
//   side moves one result per cycle while out_ready is high, so events with
//   two results use it twice; the queue (QUEUE_DEPTH entries) absorbs bursts.
// - Stall: while out_ready is low results pile up in the queue; once fewer
//   than two slots are free the evaluation stage holds and in_ready drops.
// - Reset (rst_n low, synchronous): coordinates, drift sum, moving flag,
//   touch start, tick counter and queue are cleared; config returns to its
//   default gains and thresholds.
module touchpad_gesture_tracker #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [2:0]         in_op,
  input  logic signed [15:0] in_value,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         out_kind,
  output logic signed [8:0]  out_dx,
  output logic signed [8:0]  out_dy,
  output logic               out_last,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [23:0]        cfg_data
);

  // ---------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------
  logic [23:0] x_gain_r, y_gain_r;
  logic [8:0]  jump_thr_r;
  logic [15:0] drift_thr_r, hold_ticks_r;
  logic        cfg_we;

  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_gain_r     <= tgt_pkg::RST_X_GAIN;
      y_gain_r     <= tgt_pkg::RST_Y_GAIN;
      jump_thr_r   <= tgt_pkg::RST_JUMP_THR;
      drift_thr_r  <= tgt_pkg::RST_DRIFT_THR;
      hold_ticks_r <= tgt_pkg::RST_HOLD_TICKS;
    end else if (cfg_we) begin
      unique case (cfg_index)
        tgt_pkg::CFG_X_GAIN:     x_gain_r     <= cfg_data;
        tgt_pkg::CFG_Y_GAIN:     y_gain_r     <= cfg_data;
        tgt_pkg::CFG_JUMP_THR:   jump_thr_r   <= cfg_data[8:0];
        tgt_pkg::CFG_DRIFT_THR:  drift_thr_r  <= cfg_data[15:0];
        tgt_pkg::CFG_HOLD_TICKS: hold_ticks_r <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Stage A: capture event, scale sample (multiplier lives here)
  // ---------------------------------------------------------------------
  logic       a_valid_r;
  logic [2:0] a_op_r;
  logic [7:0] a_pix_r;
  logic [7:0] pix;
  logic       in_fire, b_fire, room2;

  tgt_scale u_scale (
    .value (in_value),
    .gain  ((in_op == tgt_pkg::OP_Y) ? y_gain_r : x_gain_r),
    .pix   (pix)
  );

  // Stage B needs two free queue slots, whatever the event turns out to give
  assign b_fire   = a_valid_r && room2;
  assign in_ready = !a_valid_r || b_fire;
  assign in_fire  = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else if (in_ready) begin
      a_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      a_op_r  <= in_op;
      a_pix_r <= pix;
    end
  end

  // ---------------------------------------------------------------------
  // Stage B: tracker state and gesture decisions
  // ---------------------------------------------------------------------
  logic [7:0]  cur_x_r, cur_y_r, prev_x_r, prev_y_r;
  logic        moving_r;
  logic [15:0] drift_r;
  logic [31:0] touch_start_r, tick_r;

  logic [7:0]  cx, cy, px, py, adx, ady;
  logic [8:0]  step;
  logic [16:0] dsum;
  logic [15:0] dsat, drift_nxt;
  logic [31:0] held, start_nxt;
  logic        is_tick, is_rel, click, right, mov1, mov2, jump, motion;
  logic signed [8:0] dx, dy;
  tgt_pkg::result_t click_res, motion_res;
  tgt_pkg::push_t   push;

  always_comb begin
    cx = cur_x_r;
    cy = cur_y_r;
    px = prev_x_r;
    py = prev_y_r;
    unique case (a_op_r)
      tgt_pkg::OP_X: begin
        cx = a_pix_r;
        px = cur_x_r;
      end
      tgt_pkg::OP_Y: begin
        cy = a_pix_r;
        py = cur_y_r;
      end
      default: ;
    endcase
  end

  assign is_tick = (a_op_r == tgt_pkg::OP_TICK);
  assign is_rel  = (a_op_r == tgt_pkg::OP_REL);

  // Release: click only when the touch never went into moving mode
  assign held  = tick_r - touch_start_r;
  assign right = (held >= {16'd0, hold_ticks_r});
  assign click = is_rel && !moving_r;
  assign mov1  = is_rel ? 1'b0 : moving_r;

  // Motion check
  assign adx  = (cx > px) ? cx - px : px - cx;
  assign ady  = (cy > py) ? cy - py : py - cy;
  assign step = {1'b0, adx} + {1'b0, ady};
  assign jump = (step > jump_thr_r);
  assign dsum = {1'b0, drift_r} + {8'd0, step};
  assign dsat = dsum[16] ? 16'hFFFF : dsum[15:0];
  assign mov2 = jump ? mov1 : (mov1 || (dsat > drift_thr_r));
  assign motion = !jump && mov2;

  // A jump outside moving mode restarts the drift sum, and the touch clock when both coordinates are nonzero
  assign drift_nxt = jump ? (mov1 ? drift_r : 16'd0) : dsat;
  assign start_nxt = (jump && !mov1 && (cx != 8'd0) && (cy != 8'd0)) ?
                     tick_r : touch_start_r;

  assign dx = 9'({1'b0, cx} - {1'b0, px});
  assign dy = 9'({1'b0, cy} - {1'b0, py});

  always_comb begin
    click_res.kind = right ? tgt_pkg::KIND_RIGHT : tgt_pkg::KIND_LEFT;
    click_res.dx   = '0;
    click_res.dy   = '0;
    click_res.last = !motion;

    motion_res.kind = tgt_pkg::KIND_MOTION;
    motion_res.dx   = dx;
    motion_res.dy   = dy;
    motion_res.last = 1'b1;

    push.push0 = b_fire && !is_tick && (click || motion);
    push.push1 = b_fire && !is_tick && click && motion;
    push.r0    = click ? click_res : motion_res;
    push.r1    = motion_res;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_x_r       <= '0;
      cur_y_r       <= '0;
      prev_x_r      <= '0;
      prev_y_r      <= '0;
      moving_r      <= 1'b0;
      drift_r       <= '0;
      touch_start_r <= '0;
      tick_r        <= '0;
    end else if (b_fire) begin
      if (is_tick) begin
        tick_r <= tick_r + 32'd1;
      end else begin
        cur_x_r       <= cx;
        cur_y_r       <= cy;
        prev_x_r      <= px;
        prev_y_r      <= py;
        moving_r      <= mov2;
        drift_r       <= drift_nxt;
        touch_start_r <= start_nxt;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Result queue and output channel
  // ---------------------------------------------------------------------
  tgt_pkg::result_t head;

  tgt_result_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .pop_ready  (out_ready),
    .head_valid (out_valid),
    .head       (head),
    .room2      (room2)
  );

  assign out_kind = head.kind;
  assign out_dx   = head.dx;
  assign out_dy   = head.dy;
  assign out_last = head.last;

endmodule

[design/tgt_checker.sv]
// Port-level checks for the touchpad gesture tracker, bound to the top level.
// Uses tgt_pkg.
`timescale 1ns / 1ps

module tgt_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_ready,
  input logic [1:0]         out_kind,
  input logic signed [8:0]  out_dx,
  input logic signed [8:0]  out_dy,
  input logic               out_last
);

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_kind) && $stable(out_dx) &&
    $stable(out_dy) && $stable(out_last))
    else $error("result changed while stalled");

  // Nothing is offered in the cycle right after reset
  a_reset_empty: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(rst_n) |-> !out_valid)
    else $error("result offered right after reset");

  // Clicks carry no deltas
  a_click_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind == tgt_pkg::KIND_LEFT || out_kind == tgt_pkg::KIND_RIGHT)
    |-> out_dx == 9'sd0 && out_dy == 9'sd0)
    else $error("click with nonzero delta");

  // A motion result is always the last one of its event
  a_motion_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == tgt_pkg::KIND_MOTION |-> out_last)
    else $error("motion result not marked last");

  // A result that is not last is a click, and the motion follows it
  a_pair_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_last |=> out_valid && out_kind == tgt_pkg::KIND_MOTION)
    else $error("click not followed by its motion");

endmodule

bind touchpad_gesture_tracker tgt_checker u_tgt_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_kind  (out_kind),
  .out_dx    (out_dx),
  .out_dy    (out_dy),
  .out_last  (out_last)
);
